/* hdl/ogwd_pkg.sv */
// Shared constants, types and codes for the occupancy grid wall dilation unit.
// No dependencies; every other file imports this package.
package ogwd_pkg;

  localparam int RADIUS_ROWS = 4;
  localparam int RADIUS_COLS = 4;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;

  // field and register widths fixed by the interface
  localparam int PIX_W     = 8;
  localparam int THR_W     = 8;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // derived sizes
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int OROW_W   = $clog2(MAX_HEIGHT);
  localparam int VROW_W   = $clog2(MAX_HEIGHT + RADIUS_ROWS + 1);
  localparam int EW_W     = $clog2(MAX_WIDTH + 1);
  localparam int EH_W     = $clog2(MAX_HEIGHT + 1);
  localparam int DLY_MAX  = RADIUS_ROWS * MAX_WIDTH + RADIUS_COLS;
  localparam int DLY_W    = $clog2(DLY_MAX + 1);
  localparam int DL_DEPTH = DLY_MAX + 1;
  localparam int DL_AW    = $clog2(DL_DEPTH);
  localparam int WIN      = 2 * RADIUS_COLS + 1;
  localparam int MSK_W    = COL_W + 2;
  localparam int RS_W     = $clog2(2 * RADIUS_ROWS + 2);

  // rows-since-wall saturates one past the vertical reach
  localparam logic [RS_W-1:0] RS_SAT = RS_W'(2 * RADIUS_ROWS + 1);

  // reset geometry
  localparam int RST_THR    = 5;
  localparam int RST_WIDTH  = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_HEIGHT = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(2);

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  // one raster step leaving the sequencer
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic             row0;
    logic             wall;
    logic             emit;
    logic             last;
    logic [WIN-1:0]   mask;
  } ogwd_item_t;

  // step after the vertical update
  typedef struct packed {
    logic           valid;
    logic           vflag;
    logic           emit;
    logic           last;
    logic [WIN-1:0] mask;
  } ogwd_col_t;

endpackage

/* hdl/ogwd_pix_ram.sv */
// Pixel delay line: one write port, one registered read port.
// Depends on ogwd_pkg.
module ogwd_pix_ram
  import ogwd_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [DL_AW-1:0] waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [DL_AW-1:0] raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DL_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ogwd_ctrl.sv */
// Sequencer: configuration registers, raster counters, accept/emit decisions,
// delay-line addressing and the column window mask. Depends on ogwd_pkg.
module ogwd_ctrl
  import ogwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [PIX_W-1:0]     in_tdata,
  input  logic                 enable,
  output ogwd_item_t           item,
  output logic                 pix_we,
  output logic [DL_AW-1:0]     pix_waddr,
  output logic [PIX_W-1:0]     pix_wdata,
  output logic                 pix_re,
  output logic [DL_AW-1:0]     pix_raddr
);

  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [COL_W-1:0]  w_m1_r, w_m1_nxt;
  logic [OROW_W-1:0] h_m1_r, h_m1_nxt;
  logic [DLY_W-1:0]  dly_r, dly_nxt;

  logic [COL_W-1:0]  vcol_r, vcol_nxt;
  logic [VROW_W-1:0] vrow_r, vrow_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;
  logic [OROW_W-1:0] orow_r, orow_nxt;
  logic [DLY_W-1:0]  lag_r, lag_nxt;
  logic [DL_AW-1:0]  wptr_r, wptr_nxt;
  logic [DL_AW-1:0]  rptr_r, rptr_nxt;

  logic [WID_W-1:0]  w_raw;
  logic [HGT_W-1:0]  h_raw;
  logic [EW_W-1:0]   w_eff;
  logic [EH_W-1:0]   h_eff;
  logic              geo_wr;

  logic              in_done, lag_full, acc, real_px, adv_int, fire, emit, last;
  logic [MSK_W-1:0]  msum;
  logic [WIN-1:0]    mask;

  // ---- configuration ----
  always_comb begin
    w_raw = cfg_data[WID_W-1:0];
    h_raw = cfg_data[HGT_W-1:0];
    if (w_raw == '0) begin
      w_eff = EW_W'(1);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(w_raw);
    end
    if (h_raw == '0) begin
      h_eff = EH_W'(1);
    end else if (32'(h_raw) > 32'(MAX_HEIGHT)) begin
      h_eff = EH_W'(MAX_HEIGHT);
    end else begin
      h_eff = EH_W'(h_raw);
    end

    thr_nxt  = thr_r;
    w_m1_nxt = w_m1_r;
    h_m1_nxt = h_m1_r;
    dly_nxt  = dly_r;
    geo_wr   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_nxt = cfg_data[THR_W-1:0];
        REG_WIDTH: begin
          w_m1_nxt = COL_W'(w_eff - EW_W'(1));
          dly_nxt  = DLY_W'(DLY_W'(RADIUS_ROWS) * DLY_W'(w_eff) + DLY_W'(RADIUS_COLS));
          geo_wr   = 1'b1;
        end
        REG_HEIGHT: begin
          h_m1_nxt = OROW_W'(h_eff - EH_W'(1));
          geo_wr   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---- step decisions ----
  always_comb begin
    in_done   = vrow_r > VROW_W'(h_m1_r);
    lag_full  = lag_r == dly_r;
    in_tready = enable && (!in_done || lag_full);
    acc       = in_tvalid && in_tready;
    real_px   = acc && !in_done && (func_t'(in_tuser) == FUNC_PIXEL);
    // after the last pixel, virtual steps run until the lag reaches the delay
    adv_int   = enable && in_done && !lag_full;
    fire      = real_px || adv_int || (acc && in_done);
    emit      = (real_px && lag_full) || (acc && in_done);
    last      = emit && (ocol_r == w_m1_r) && (orow_r == h_m1_r);
  end

  // which window taps fall inside the output pixel's row
  always_comb begin
    msum = MSK_W'(ocol_r) + MSK_W'(RADIUS_COLS);
    for (int j = 0; j < WIN; j++) begin
      mask[j] = (msum >= MSK_W'(j)) && (msum <= MSK_W'(w_m1_r) + MSK_W'(j));
    end
  end

  // ---- counters ----
  always_comb begin
    vcol_nxt = vcol_r;
    vrow_nxt = vrow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    lag_nxt  = lag_r;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (fire) begin
      if (vcol_r == w_m1_r) begin
        vcol_nxt = '0;
        vrow_nxt = vrow_r + VROW_W'(1);
      end else begin
        vcol_nxt = vcol_r + COL_W'(1);
      end
      if (!emit) begin
        lag_nxt = lag_r + DLY_W'(1);
      end
    end
    if (real_px) begin
      wptr_nxt = (wptr_r == DL_AW'(DL_DEPTH - 1)) ? '0 : wptr_r + DL_AW'(1);
    end
    if (emit) begin
      rptr_nxt = (rptr_r == DL_AW'(DL_DEPTH - 1)) ? '0 : rptr_r + DL_AW'(1);
      if (ocol_r == w_m1_r) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + OROW_W'(1);
      end else begin
        ocol_nxt = ocol_r + COL_W'(1);
      end
    end
    if (last || geo_wr) begin
      vcol_nxt = '0;
      vrow_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
      lag_nxt  = '0;
      wptr_nxt = '0;
      rptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_W'(RST_THR);
      w_m1_r <= COL_W'(RST_WIDTH - 1);
      h_m1_r <= OROW_W'(RST_HEIGHT - 1);
      dly_r  <= DLY_W'(RADIUS_ROWS * RST_WIDTH + RADIUS_COLS);
      vcol_r <= '0;
      vrow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      lag_r  <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      thr_r  <= thr_nxt;
      w_m1_r <= w_m1_nxt;
      h_m1_r <= h_m1_nxt;
      dly_r  <= dly_nxt;
      vcol_r <= vcol_nxt;
      vrow_r <= vrow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      lag_r  <= lag_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_comb begin
    item.valid = fire;
    item.col   = vcol_r;
    item.row0  = vrow_r == '0;
    item.wall  = real_px && (in_tdata <= thr_r);
    item.emit  = emit;
    item.last  = last;
    item.mask  = mask;
  end

  assign pix_we    = real_px;
  assign pix_waddr = wptr_r;
  assign pix_wdata = in_tdata;
  assign pix_re    = emit;
  assign pix_raddr = rptr_r;

endmodule

/* hdl/ogwd_col_mem.sv */
// Per-column rows-since-wall memory with read-modify-write and forwarding;
// produces the vertical wall flag of each step. Depends on ogwd_pkg.
module ogwd_col_mem
  import ogwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       enable,
  input  ogwd_item_t item,
  output ogwd_col_t  col_o
);

  logic [RS_W-1:0]  rs_mem [MAX_WIDTH];
  logic [RS_W-1:0]  rs_rd_r;
  ogwd_item_t       s1_r;
  logic             fwd_v_r;
  logic [COL_W-1:0] fwd_col_r;
  logic [RS_W-1:0]  fwd_rs_r;
  logic [RS_W-1:0]  rs_prev, rs_new;

  always_ff @(posedge clk) begin
    if (enable && item.valid) begin
      rs_rd_r <= rs_mem[item.col];
    end
    if (enable && s1_r.valid) begin
      rs_mem[s1_r.col] <= rs_new;
      fwd_col_r        <= s1_r.col;
      fwd_rs_r         <= rs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r    <= '0;
      fwd_v_r <= 1'b0;
    end else if (enable) begin
      s1_r <= item;
      if (s1_r.valid) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // the write that lands on the read's edge is not in rs_rd_r
  always_comb begin
    rs_prev = (fwd_v_r && (fwd_col_r == s1_r.col)) ? fwd_rs_r : rs_rd_r;
    if (s1_r.wall) begin
      rs_new = '0;
    end else if (s1_r.row0 || (rs_prev >= RS_SAT)) begin
      // row 0 ignores whatever an earlier image left
      rs_new = RS_SAT;
    end else begin
      rs_new = rs_prev + RS_W'(1);
    end
  end

  always_comb begin
    col_o.valid = s1_r.valid;
    col_o.vflag = rs_new < RS_SAT;
    col_o.emit  = s1_r.emit;
    col_o.last  = s1_r.last;
    col_o.mask  = s1_r.mask;
  end

endmodule

/* hdl/ogwd_win_out.sv */
// Horizontal flag window, final pixel select and output register with skid.
// Depends on ogwd_pkg.
module ogwd_win_out
  import ogwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ogwd_col_t        col_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic             enable,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic [WIN-1:0]   win_r;
  logic             s2_v_r;
  logic             s2_last_r;
  logic [WIN-1:0]   s2_mask_r;
  logic [PIX_W-1:0] s2_pix_r;
  logic             out_v_r, skid_v_r;
  logic [PIX_W-1:0] out_pix_r, skid_pix_r;
  logic             out_last_r, skid_last_r;
  logic             hit, push;
  logic [PIX_W-1:0] res_pix;

  assign enable = !skid_v_r;

  // bit 0 is the newest column flag
  always_ff @(posedge clk) begin
    if (enable && col_i.valid) begin
      win_r <= {win_r[WIN-2:0], col_i.vflag};
    end
    if (enable) begin
      s2_last_r <= col_i.last;
      s2_mask_r <= col_i.mask;
      s2_pix_r  <= pix_i;
    end
  end

  always_comb begin
    hit     = |(win_r & s2_mask_r);
    res_pix = hit ? '0 : s2_pix_r;
    push    = enable && s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (enable) begin
        s2_v_r <= col_i.valid && col_i.emit;
      end
      if (!out_v_r || out_tready) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_pix_r  <= skid_pix_r;
        out_last_r <= skid_last_r;
      end else if (push) begin
        out_pix_r  <= res_pix;
        out_last_r <= s2_last_r;
      end
    end else if (push) begin
      skid_pix_r  <= res_pix;
      skid_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

/* hdl/occupancy_grid_wall_dilation_unit.sv */
// Top level of the occupancy grid wall dilation unit.
// Depends on ogwd_pkg, ogwd_ctrl, ogwd_pix_ram, ogwd_col_mem, ogwd_win_out.
//
//   channel | direction | tdata          | tuser      | tlast
//   in_     | slave     | [7:0] pixel_in | [0] func   | -
//   out_    | master    | [7:0] pixel_out| -          | [0] last_pixel
//   cfg_    | write     | cfg_data[12:0] at cfg_index, on cfg_we
//
// One item per clock while the skid register is empty; a result passes the
// registered column memory and window stages to the output register. After
// the last pixel of an image smaller than the delay (4*width+4), internal
// flush steps run with in_tready low until the lag equals the delay. Reset is
// synchronous; the column memory needs no clearing pass as row 0 ignores its
// contents. A stall fills the output and skid registers, then in_tready drops.
module occupancy_grid_wall_dilation_unit
  import ogwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // [7:0] pixel_in
  input  logic                 in_tuser,   // [0] func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // [7:0] pixel_out
  output logic                 out_tlast
);

  ogwd_item_t       item;
  ogwd_col_t        col;
  logic             enable;
  logic             pix_we, pix_re;
  logic [DL_AW-1:0] pix_waddr, pix_raddr;
  logic [PIX_W-1:0] pix_wdata, pix_rdata;

  ogwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .enable    (enable),
    .item      (item),
    .pix_we    (pix_we),
    .pix_waddr (pix_waddr),
    .pix_wdata (pix_wdata),
    .pix_re    (pix_re),
    .pix_raddr (pix_raddr)
  );

  ogwd_pix_ram u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  ogwd_col_mem u_col_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .enable (enable),
    .item   (item),
    .col_o  (col)
  );

  ogwd_win_out u_win_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .col_i      (col),
    .pix_i      (pix_rdata),
    .enable     (enable),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hdl/ogwd_checker.sv */
// Port-level checks for the wall dilation unit, bound to the top level.
// Depends on ogwd_pkg.
module ogwd_checker
  import ogwd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [PIX_W-1:0]     out_tdata,
  input logic                 out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind occupancy_grid_wall_dilation_unit ogwd_checker u_ogwd_checker (.*);
